// File: design/triangle_unit_normal_assert.svh
// Assertion helpers for the triangle unit normal block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define TUN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TUN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TUN_ASSERT_SAME(label, ante, cons, msg)
`define TUN_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: design/tun_pkg.sv
package tun_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = 16;
  localparam int AXES          = 3;

  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
  localparam int MAG_WIDTH  = PROD_WIDTH + 1;
  localparam int LO_WIDTH   = (MAG_WIDTH + 1) / 2;
  localparam int HI_WIDTH   = MAG_WIDTH - LO_WIDTH;
  localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH  = SQ_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [OUT_WIDTH-1:0]   norm_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_req_t;

  typedef struct packed {
    norm_t norm_x;
    norm_t norm_y;
    norm_t norm_z;
    logic  degenerate;
  } out_req_t;

  // squared cross product component and the sign of the component
  typedef struct packed {
    logic                neg;
    logic [SQ_WIDTH-1:0] sq;
  } sq_res_t;

endpackage

// File: design/triangle_unit_normal.sv
// Unit face normal of a triangle.
//
// Input channel in_valid/in_ready/in_data carries one request: the three
// vertices a, b, c as signed Q8.8 coordinates. The output channel
// out_valid/out_ready/out_data returns the unit normal of (a-b) x (a-c) as
// signed Q2.14 components, each rounded to nearest with ties away from zero.
// A zero cross product returns a zero vector with degenerate set.
//
// Throughput: one request per cycle while the receiver does not stall the
// last stage. The depth comes from the edge difference, the cross product
// lanes, the sum, the per-lane restoring divider (2*FRAC_BITS+3 stages) and
// the per-lane root extractor (FRAC_BITS+2 stages), one bit each per stage.
//
// Reset (rst_n low, synchronous) empties the pipeline and the output
// register. When the receiver stalls, the output register holds its request
// and the pipeline keeps moving until a finished request reaches its last
// stage; only then does in_ready drop and everything hold.
`include "triangle_unit_normal_assert.svh"

module triangle_unit_normal #(
  parameter int FRAC_BITS = tun_pkg::OUT_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tun_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tun_pkg::out_req_t out_data
);
  import tun_pkg::*;

  localparam int QB  = 2 * FRAC_BITS + 3;
  localparam int RB  = FRAC_BITS + 2;
  localparam int DL  = QB + RB + 1;   // scale lane depth
  localparam int LAT = 6 + DL;        // diff, 4 cross stages, sum, scale lane

  logic                 en;
  logic                 accept;
  logic [LAT-1:0]       vld_r;
  logic [DL-1:0]        degen_r;
  diff_t                d1_r [AXES];
  diff_t                d2_r [AXES];
  sq_res_t              sq_res [AXES];
  sq_res_t              sq_d_r [AXES];
  logic [SUM_WIDTH-1:0] sum_r;
  norm_t                norm [AXES];
  logic                 out_valid_r;
  out_req_t             out_data_r;
  logic                 out_load;

  // freeze only when a finished request cannot move into the output register
  assign en       = !(vld_r[LAT-1] && out_valid_r && !out_ready);
  assign in_ready = en;
  assign accept   = in_valid && in_ready;
  assign out_load = out_ready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // edge vectors d1 = a - b, d2 = a - c
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= DIFF_WIDTH'(in_data.a_x) - DIFF_WIDTH'(in_data.b_x);
      d1_r[1] <= DIFF_WIDTH'(in_data.a_y) - DIFF_WIDTH'(in_data.b_y);
      d1_r[2] <= DIFF_WIDTH'(in_data.a_z) - DIFF_WIDTH'(in_data.b_z);
      d2_r[0] <= DIFF_WIDTH'(in_data.a_x) - DIFF_WIDTH'(in_data.c_x);
      d2_r[1] <= DIFF_WIDTH'(in_data.a_y) - DIFF_WIDTH'(in_data.c_y);
      d2_r[2] <= DIFF_WIDTH'(in_data.a_z) - DIFF_WIDTH'(in_data.c_z);
    end
  end

  // one cross product lane per axis
  for (genvar i = 0; i < AXES; i++) begin : g_cross
    localparam int J = (i + 1) % AXES;
    localparam int K = (i + 2) % AXES;
    tun_cross_lane u_cross (
      .clk  (clk),
      .en   (en),
      .d1_j (d1_r[J]),
      .d2_k (d2_r[K]),
      .d1_k (d1_r[K]),
      .d2_j (d2_r[J]),
      .res  (sq_res[i])
    );
  end

  // squared length, with the per-axis squares held alongside it
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SUM_WIDTH'(sq_res[0].sq) + SUM_WIDTH'(sq_res[1].sq)
             + SUM_WIDTH'(sq_res[2].sq);
      for (int i = 0; i < AXES; i++) begin
        sq_d_r[i] <= sq_res[i];
      end
      degen_r <= {degen_r[DL-2:0], sum_r == '0};
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_scale
    tun_scale_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_scale (
      .clk    (clk),
      .en     (en),
      .in_res (sq_d_r[i]),
      .sum    (sum_r),
      .norm   (norm[i])
    );
  end

  // merge the lanes; drop the lane values of a degenerate triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld_r[LAT-1]) begin
      out_data_r.degenerate <= degen_r[DL-1];
      out_data_r.norm_x     <= degen_r[DL-1] ? '0 : norm[0];
      out_data_r.norm_y     <= degen_r[DL-1] ? '0 : norm[1];
      out_data_r.norm_z     <= degen_r[DL-1] ? '0 : norm[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TUN_ASSERT_SAME(a_degen_zero, out_valid && out_data.degenerate, out_data.norm_x == '0 && out_data.norm_y == '0 && out_data.norm_z == '0, "degenerate result with nonzero normal")
  `TUN_ASSERT_SAME(a_stall_blocks, vld_r[LAT-1] && out_valid_r && !out_ready, !in_ready, "request accepted while the pipeline is blocked")
  `TUN_ASSERT_NEXT(a_accept_enters, accept, vld_r[0], "accepted request did not enter the pipeline")

endmodule

// File: design/tun_cross_lane.sv
module tun_cross_lane (
  input  logic             clk,
  input  logic             en,
  input  tun_pkg::diff_t   d1_j,
  input  tun_pkg::diff_t   d2_k,
  input  tun_pkg::diff_t   d1_k,
  input  tun_pkg::diff_t   d2_j,
  output tun_pkg::sq_res_t res
);
  import tun_pkg::*;

  logic signed [PROD_WIDTH-1:0] t1_r;
  logic signed [PROD_WIDTH-1:0] t2_r;
  logic signed [MAG_WIDTH-1:0]  p;
  logic [MAG_WIDTH-1:0]         mag;
  logic [MAG_WIDTH-1:0]         mag_r;
  logic                         neg_mag_r;
  logic [HI_WIDTH-1:0]          hi;
  logic [LO_WIDTH-1:0]          lo;
  logic [2*HI_WIDTH-1:0]        hh_r;
  logic [HI_WIDTH+LO_WIDTH-1:0] hl_r;
  logic [2*LO_WIDTH-1:0]        ll_r;
  logic                         neg_part_r;
  logic [SQ_WIDTH-1:0]          sq_r;
  logic                         neg_sq_r;

  assign p   = MAG_WIDTH'(t1_r) - MAG_WIDTH'(t2_r);
  assign mag = p[MAG_WIDTH-1] ? $unsigned(-p) : $unsigned(p);
  assign lo  = mag_r[LO_WIDTH-1:0];
  assign hi  = mag_r[MAG_WIDTH-1:LO_WIDTH];

  // split the square into three narrow partial products
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r       <= PROD_WIDTH'(d1_j) * PROD_WIDTH'(d2_k);
      t2_r       <= PROD_WIDTH'(d1_k) * PROD_WIDTH'(d2_j);
      mag_r      <= mag;
      neg_mag_r  <= p[MAG_WIDTH-1];
      hh_r       <= hi * hi;
      hl_r       <= hi * lo;
      ll_r       <= lo * lo;
      neg_part_r <= neg_mag_r;
      sq_r       <= (SQ_WIDTH'(hh_r) << (2 * LO_WIDTH))
                  + (SQ_WIDTH'(hl_r) << (LO_WIDTH + 1))
                  + SQ_WIDTH'(ll_r);
      neg_sq_r   <= neg_part_r;
    end
  end

  assign res.neg = neg_sq_r;
  assign res.sq  = sq_r;

endmodule

// File: design/tun_scale_lane.sv
module tun_scale_lane #(
  parameter int FRAC_BITS = tun_pkg::OUT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  tun_pkg::sq_res_t              in_res,
  input  logic [tun_pkg::SUM_WIDTH-1:0] sum,
  output tun_pkg::norm_t                norm
);
  import tun_pkg::*;

  localparam int QB = 2 * FRAC_BITS + 3;  // quotient bits of c2 * 4^(F+1) / S
  localparam int RB = FRAC_BITS + 2;      // root bits
  localparam int TW = QB + 1;

  logic [SUM_WIDTH-1:0] drem_r [QB];
  logic [SUM_WIDTH-1:0] dden_r [QB];
  logic [QB-1:0]        quo_r  [QB];
  logic                 dneg_r [QB];

  logic [QB-1:0] srem_r  [RB];
  logic [RB-1:0] root_r  [RB];
  logic          sneg_r  [RB];

  logic [RB:0]          rounded;
  logic signed [RB:0]   mag_s;
  norm_t                norm_r;

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int PREV = (i == 0) ? 0 : i - 1;
    logic [SUM_WIDTH-1:0] rem_in;
    logic [SUM_WIDTH-1:0] den_in;
    logic [QB-1:0]        quo_in;
    logic                 neg_in;
    logic [SUM_WIDTH:0]   shifted;
    logic                 fits;

    always_comb begin
      rem_in  = (i == 0) ? SUM_WIDTH'(in_res.sq) : drem_r[PREV];
      den_in  = (i == 0) ? sum : dden_r[PREV];
      quo_in  = (i == 0) ? '0 : quo_r[PREV];
      neg_in  = (i == 0) ? in_res.neg : dneg_r[PREV];
      shifted = (i == 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
      fits    = shifted >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[i] <= fits ? SUM_WIDTH'(shifted - {1'b0, den_in}) : SUM_WIDTH'(shifted);
        dden_r[i] <= den_in;
        quo_r[i]  <= {quo_in[QB-2:0], fits};
        dneg_r[i] <= neg_in;
      end
    end
  end

  // integer square root, one root bit per stage
  for (genvar j = 0; j < RB; j++) begin : g_root
    localparam int PREV = (j == 0) ? 0 : j - 1;
    localparam int B    = RB - 1 - j;
    logic [QB-1:0] rem_in;
    logic [RB-1:0] root_in;
    logic          neg_in;
    logic [TW-1:0] trial;
    logic          fits;

    always_comb begin
      rem_in  = (j == 0) ? quo_r[QB-1] : srem_r[PREV];
      root_in = (j == 0) ? '0 : root_r[PREV];
      neg_in  = (j == 0) ? dneg_r[QB-1] : sneg_r[PREV];
      trial   = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
      fits    = TW'(rem_in) >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j] <= fits ? QB'(TW'(rem_in) - trial) : rem_in;
        root_r[j] <= root_in | (RB'(fits) << B);
        sneg_r[j] <= neg_in;
      end
    end
  end

  // largest odd m <= root gives n = (m + 1) / 2
  assign rounded = ({1'b0, root_r[RB-1]} + (RB + 1)'(1)) >> 1;
  assign mag_s   = $signed(rounded);

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= OUT_WIDTH'(sneg_r[RB-1] ? -mag_s : mag_s);
    end
  end

  assign norm = norm_r;

endmodule
